// ----- rtl/lfp_pkg.sv -----
`default_nettype none
package lfp_pkg;

  localparam int POS_W   = 20;
  localparam int LIMIT_W = 10;
  localparam int COST_W  = 30;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  typedef struct packed {
    logic [POS_W-1:0] house_position;
    logic             last_house;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_total_distance;
    logic              too_many_houses;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/line_facility_placement_dp.sv -----
// Line facility placement (1-D k-median) solver.
// Input queue: house positions arrive on in_data while push is high and
// full is low, one transaction per cycle. last_house ends a batch.
// Up to MAX_HOUSES houses are kept; later ones are dropped and flagged.
// After the last house, full stays high while the batch is sorted and
// solved: insertion sort, a prefix pass, then a dynamic program over
// facility counts using divide-and-conquer on a monotone split; every
// candidate evaluation goes through the shared run-cost unit.
// Output queue: one result per batch on out_data while empty is low,
// taken when pop is high. A waiting result does not block loading the
// next batch; solving of that batch starts once the result slot is free.
// cfg_data (facility limit, reset 1) is written when cfg_valid is high;
// cfg_ready is always high. Write only while the block is idle.
// Reset (rst_n low, synchronous) clears the batch count, overflow flag,
// job queue and result slot.
`default_nettype none
module line_facility_placement_dp #(
  parameter int MAX_HOUSES = 512
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  output logic                       full,
  input  lfp_pkg::in_item_t          in_data,
  output logic                       empty,
  input  wire                        pop,
  output lfp_pkg::out_item_t         out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [lfp_pkg::LIMIT_W-1:0] cfg_data
);
  import lfp_pkg::*;

  localparam int IW = $clog2(MAX_HOUSES + 1);

  logic [LIMIT_W-1:0] limit_r;
  logic               back_busy, jobq_nempty, job_push, job_pop;
  logic [IW:0]        job_wdata, job_rdata;
  logic               fw_en, res_valid;
  logic [IW-1:0]      fw_addr;
  logic [POS_W-1:0]   fw_data;

  assign cfg_ready = 1'b1;
  assign empty     = ~res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_valid) limit_r <= cfg_data;
  end

  lfp_front #(.MAX_HOUSES(MAX_HOUSES), .IW(IW)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
    .back_busy(back_busy), .jobq_nempty(jobq_nempty),
    .wr_en(fw_en), .wr_addr(fw_addr), .wr_data(fw_data),
    .job_push(job_push), .job_data(job_wdata)
  );

  lfp_jobq #(.W(IW + 1)) u_jobq (
    .clk(clk), .rst_n(rst_n), .wr(job_push), .wdata(job_wdata),
    .rd(job_pop), .nempty(jobq_nempty), .rdata(job_rdata)
  );

  lfp_back #(.MAX_HOUSES(MAX_HOUSES), .IW(IW)) u_back (
    .clk(clk), .rst_n(rst_n), .limit(limit_r),
    .fw_en(fw_en), .fw_addr(fw_addr), .fw_data(fw_data),
    .job_nempty(jobq_nempty), .job_data(job_rdata), .job_pop(job_pop),
    .busy(back_busy), .res_valid(res_valid), .res_data(out_data),
    .res_pop(pop)
  );

endmodule
`default_nettype wire

// ----- rtl/lfp_front.sv -----
`default_nettype none
module lfp_front #(
  parameter int MAX_HOUSES = 512,
  parameter int IW = 10
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  lfp_pkg::in_item_t        in_data,
  output logic                     full,
  input  wire                      back_busy,
  input  wire                      jobq_nempty,
  output logic                     wr_en,
  output logic [IW-1:0]            wr_addr,
  output logic [lfp_pkg::POS_W-1:0] wr_data,
  output logic                     job_push,
  output logic [IW:0]              job_data
);
  import lfp_pkg::*;

  logic [IW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          accept, room;

  assign full    = back_busy | jobq_nempty;
  assign accept  = push & ~full;
  assign room    = (count_r < IW'(MAX_HOUSES));
  assign wr_en   = accept & room;
  assign wr_addr = count_r + IW'(1);
  assign wr_data = in_data.house_position;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    job_push  = 1'b0;
    job_data  = {count_r + IW'(room), ovf_r | ~room};
    if (accept) begin
      if (room) count_nxt = count_r + IW'(1);
      else ovf_nxt = 1'b1;
      if (in_data.last_house) begin
        job_push  = 1'b1;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lfp_jobq.sv -----
`default_nettype none
module lfp_jobq #(
  parameter int W = 11
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          wr,
  input  wire [W-1:0]  wdata,
  input  wire          rd,
  output logic         nempty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign nempty = (cnt_r != 2'd0);
  assign rdata  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && cnt_r != 2'd2) ent_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && cnt_r != 2'd2) wp_r <= ~wp_r;
      if (rd && nempty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr && cnt_r != 2'd2) - 2'(rd && nempty);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lfp_back.sv -----
`default_nettype none
module lfp_back #(
  parameter int MAX_HOUSES = 512,
  parameter int IW = 10
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [lfp_pkg::LIMIT_W-1:0] limit,
  input  wire                        fw_en,
  input  wire [IW-1:0]               fw_addr,
  input  wire [lfp_pkg::POS_W-1:0]   fw_data,
  input  wire                        job_nempty,
  input  wire [IW:0]                 job_data,
  output logic                       job_pop,
  output logic                       busy,
  output logic                       res_valid,
  output lfp_pkg::out_item_t         res_data,
  input  wire                        res_pop
);
  import lfp_pkg::*;

  localparam int DEPTH = MAX_HOUSES + 1;
  localparam int PW    = POS_W + IW;
  localparam int SW    = (PW > COST_W) ? PW : COST_W;
  localparam int CMW   = (IW > LIMIT_W) ? IW : LIMIT_W;
  localparam int SD    = IW + 2;
  localparam int SPW   = $clog2(SD + 1);
  localparam int SIW   = $clog2(SD);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SK    = 5'd1;
  localparam logic [4:0] S_SK2   = 5'd2;
  localparam logic [4:0] S_SC    = 5'd3;
  localparam logic [4:0] S_PR    = 5'd4;
  localparam logic [4:0] S_PW    = 5'd5;
  localparam logic [4:0] S_RC0   = 5'd6;
  localparam logic [4:0] S_RC1   = 5'd7;
  localparam logic [4:0] S_RC2   = 5'd8;
  localparam logic [4:0] S_RC3   = 5'd9;
  localparam logic [4:0] S_ROW   = 5'd10;
  localparam logic [4:0] S_POP   = 5'd11;
  localparam logic [4:0] S_PUSHR = 5'd12;
  localparam logic [4:0] S_PUSHL = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_FIN2  = 5'd15;

  // memories
  logic [POS_W-1:0] pos_mem [DEPTH];
  logic [PW-1:0]    pre_mem [DEPTH];
  logic [PW-1:0]    cost0_mem [DEPTH];
  logic [PW-1:0]    cost1_mem [DEPTH];

  logic [POS_W-1:0] pos_rd_r;
  logic [PW-1:0]    pre_rd0_r, pre_rd1_r, c0_rd_r, c1_rd_r;

  logic             pw_en;
  logic [IW-1:0]    pw_addr, pos_ra;
  logic [POS_W-1:0] pw_data;
  logic             prw_en;
  logic [IW-1:0]    prw_addr, pre_ra0, pre_ra1;
  logic [PW-1:0]    prw_data;
  logic             cw0_en, cw1_en;
  logic [IW-1:0]    cw_addr, cost_ra;
  logic [PW-1:0]    cw_data;

  // control and datapath registers
  logic [4:0]         state_r, state_nxt;
  logic [IW-1:0]      n_r, n_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic [POS_W-1:0]   key_r, key_nxt;
  logic [PW-1:0]      sum_r, sum_nxt;
  logic [LIMIT_W-1:0] lim_r, lim_nxt;
  logic [LIMIT_W-1:0] t_r, t_nxt;
  logic               sel_r, sel_nxt;
  logic               dc_r, dc_nxt;
  logic [IW-1:0]      rci_r, rci_nxt;
  logic [IW-1:0]      rcj_r, rcj_nxt;
  logic [IW-1:0]      m_r, m_nxt;
  logic [POS_W-1:0]   a_r, a_nxt;
  logic [PW-1:0]      pm_r, pm_nxt, pi_r, pi_nxt, pj_r, pj_nxt;
  logic [PW-1:0]      prevc_r, prevc_nxt;
  logic [PW-1:0]      la_r, la_nxt, rb_r, rb_nxt;
  logic [IW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, olo_r, olo_nxt, ohi_r, ohi_nxt;
  logic [IW-1:0]      mid_r, mid_nxt, top_r, top_nxt, j_r, j_nxt, bj_r, bj_nxt;
  logic [PW-1:0]      best_r, best_nxt;
  logic               first_r, first_nxt;
  logic [4*IW-1:0]    stk_r [SD];
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic               stk_we;
  logic [4*IW-1:0]    stk_wd;
  logic               res_valid_r, res_valid_nxt;
  out_item_t          res_r, res_nxt;

  logic [LIMIT_W-1:0] lim_eff;
  logic [IW-1:0]      jn_cnt;
  logic [PW-1:0]      prev_rd, rc, cand, fin_cost;
  logic [SPW-1:0]     spm1;
  logic [4*IW-1:0]    stk_top;
  logic [IW-1:0]      p_lo, p_hi, p_olo, p_ohi, p_mid, p_mm1;
  logic [SW-1:0]      fin_w;

  assign jn_cnt   = job_data[IW:1];
  assign lim_eff  = (limit == '0) ? LIMIT_W'(1) : limit;
  assign prev_rd  = sel_r ? c1_rd_r : c0_rd_r;
  assign rc       = (la_r - (pm_r - pi_r)) + ((pj_r - pm_r) - rb_r);
  assign cand     = prevc_r + rc;
  assign spm1     = sp_r - SPW'(1);
  assign stk_top  = stk_r[spm1[SIW-1:0]];
  assign p_lo     = stk_top[4*IW-1:3*IW];
  assign p_hi     = stk_top[3*IW-1:2*IW];
  assign p_olo    = stk_top[2*IW-1:IW];
  assign p_ohi    = stk_top[IW-1:0];
  assign p_mid    = p_lo + ((p_hi - p_lo) >> 1);
  assign p_mm1    = p_mid - IW'(1);
  assign fin_w    = SW'(prev_rd);
  assign fin_cost = prev_rd;

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (prw_en) pre_mem[prw_addr] <= prw_data;
    pre_rd0_r <= pre_mem[pre_ra0];
    pre_rd1_r <= pre_mem[pre_ra1];
  end

  always_ff @(posedge clk) begin
    if (cw0_en) cost0_mem[cw_addr] <= cw_data;
    c0_rd_r <= cost0_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (cw1_en) cost1_mem[cw_addr] <= cw_data;
    c1_rd_r <= cost1_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_r[sp_r[SIW-1:0]] <= stk_wd;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;       ovf_nxt = ovf_r;   i_nxt = i_r;     k_nxt = k_r;
    key_nxt = key_r;   sum_nxt = sum_r;   lim_nxt = lim_r; t_nxt = t_r;
    sel_nxt = sel_r;   dc_nxt = dc_r;     rci_nxt = rci_r; rcj_nxt = rcj_r;
    m_nxt = m_r;       a_nxt = a_r;       pm_nxt = pm_r;   pi_nxt = pi_r;
    pj_nxt = pj_r;     prevc_nxt = prevc_r;
    la_nxt = la_r;     rb_nxt = rb_r;
    lo_nxt = lo_r;     hi_nxt = hi_r;     olo_nxt = olo_r; ohi_nxt = ohi_r;
    mid_nxt = mid_r;   top_nxt = top_r;   j_nxt = j_r;     bj_nxt = bj_r;
    best_nxt = best_r; first_nxt = first_r; sp_nxt = sp_r;
    res_valid_nxt = res_valid_r & ~res_pop;
    res_nxt = res_r;
    job_pop = 1'b0;

    pw_en = fw_en;  pw_addr = fw_addr;  pw_data = fw_data;
    pos_ra = i_r;
    prw_en = 1'b0;  prw_addr = i_r;  prw_data = '0;
    pre_ra0 = m_r;  pre_ra1 = rci_r - IW'(1);
    cw0_en = 1'b0;  cw1_en = 1'b0;  cw_addr = '0;  cw_data = '0;
    cost_ra = rci_r - IW'(1);
    stk_we = 1'b0;
    stk_wd = {lo_r, hi_r, olo_r, ohi_r};

    case (state_r)
      S_IDLE: begin
        if (job_nempty && !res_valid_r) begin
          job_pop = 1'b1;
          n_nxt   = jn_cnt;
          ovf_nxt = job_data[0];
          lim_nxt = lim_eff;
          prw_en  = 1'b1;
          prw_addr = '0;
          cw0_en  = 1'b1;
          cw1_en  = 1'b1;
          if (CMW'(jn_cnt) <= CMW'(lim_eff)) begin
            res_valid_nxt = 1'b1;
            res_nxt.min_total_distance = '0;
            res_nxt.too_many_houses = job_data[0];
          end else begin
            i_nxt = IW'(2);
            state_nxt = S_SK;
          end
        end
      end
      S_SK: begin
        pos_ra = i_r;
        state_nxt = S_SK2;
      end
      S_SK2: begin
        key_nxt = pos_rd_r;
        k_nxt = i_r;
        pos_ra = i_r - IW'(1);
        state_nxt = S_SC;
      end
      S_SC: begin
        pos_ra = k_r - IW'(2);
        pw_en = 1'b1;
        pw_addr = k_r;
        if (k_r > IW'(1) && pos_rd_r > key_r) begin
          pw_data = pos_rd_r;
          k_nxt = k_r - IW'(1);
        end else begin
          pw_data = key_r;
          if (i_r == n_r) begin
            i_nxt = IW'(1);
            sum_nxt = '0;
            state_nxt = S_PR;
          end else begin
            i_nxt = i_r + IW'(1);
            state_nxt = S_SK;
          end
        end
      end
      S_PR: begin
        pos_ra = i_r;
        state_nxt = S_PW;
      end
      S_PW: begin
        sum_nxt = sum_r + PW'(pos_rd_r);
        prw_en = 1'b1;
        prw_addr = i_r;
        prw_data = sum_r + PW'(pos_rd_r);
        if (i_r == n_r) begin
          rci_nxt = IW'(1);
          rcj_nxt = IW'(1);
          dc_nxt = 1'b0;
          state_nxt = S_RC0;
        end else begin
          i_nxt = i_r + IW'(1);
          state_nxt = S_PR;
        end
      end
      S_RC0: begin
        m_nxt = rci_r + ((rcj_r - rci_r) >> 1);
        pos_ra = rci_r + ((rcj_r - rci_r) >> 1);
        pre_ra0 = rci_r + ((rcj_r - rci_r) >> 1);
        pre_ra1 = rci_r - IW'(1);
        cost_ra = rci_r - IW'(1);
        state_nxt = S_RC1;
      end
      S_RC1: begin
        a_nxt = pos_rd_r;
        pm_nxt = pre_rd0_r;
        pi_nxt = pre_rd1_r;
        prevc_nxt = prev_rd;
        pre_ra0 = rcj_r;
        state_nxt = S_RC2;
      end
      S_RC2: begin
        pj_nxt = pre_rd0_r;
        la_nxt = PW'(a_r) * PW'(m_r - rci_r + IW'(1));
        rb_nxt = PW'(a_r) * PW'(rcj_r - m_r);
        state_nxt = S_RC3;
      end
      S_RC3: begin
        if (!dc_r) begin
          cw_addr = rcj_r;
          cw_data = rc;
          cw0_en = ~sel_r;
          cw1_en = sel_r;
          if (rcj_r == n_r) begin
            t_nxt = LIMIT_W'(2);
            state_nxt = (lim_r == LIMIT_W'(1)) ? S_FIN : S_ROW;
          end else begin
            rcj_nxt = rcj_r + IW'(1);
            state_nxt = S_RC0;
          end
        end else begin
          first_nxt = 1'b0;
          if (first_r || cand < best_r) begin
            best_nxt = cand;
            bj_nxt = j_r;
          end
          if (j_r == top_r) begin
            state_nxt = S_PUSHR;
          end else begin
            j_nxt = j_r + IW'(1);
            rci_nxt = rci_r + IW'(1);
            state_nxt = S_RC0;
          end
        end
      end
      S_ROW: begin
        stk_we = 1'b1;
        stk_wd = {IW'(1), n_r, IW'(0), n_r - IW'(1)};
        sp_nxt = SPW'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          sel_nxt = ~sel_r;
          if (t_r == lim_r) begin
            state_nxt = S_FIN;
          end else begin
            t_nxt = t_r + LIMIT_W'(1);
            state_nxt = S_ROW;
          end
        end else begin
          sp_nxt = spm1;
          lo_nxt = p_lo;
          hi_nxt = p_hi;
          olo_nxt = p_olo;
          ohi_nxt = p_ohi;
          mid_nxt = p_mid;
          top_nxt = (p_ohi < p_mm1) ? p_ohi : p_mm1;
          j_nxt = p_olo;
          first_nxt = 1'b1;
          rci_nxt = p_olo + IW'(1);
          rcj_nxt = p_mid;
          dc_nxt = 1'b1;
          state_nxt = S_RC0;
        end
      end
      S_PUSHR: begin
        cw_addr = mid_r;
        cw_data = best_r;
        cw0_en = sel_r;
        cw1_en = ~sel_r;
        if (mid_r < hi_r) begin
          stk_we = 1'b1;
          stk_wd = {mid_r + IW'(1), hi_r, bj_r, ohi_r};
          sp_nxt = sp_r + SPW'(1);
        end
        state_nxt = S_PUSHL;
      end
      S_PUSHL: begin
        if (mid_r > lo_r) begin
          stk_we = 1'b1;
          stk_wd = {lo_r, mid_r - IW'(1), olo_r, bj_r};
          sp_nxt = sp_r + SPW'(1);
        end
        state_nxt = S_POP;
      end
      S_FIN: begin
        cost_ra = n_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        res_valid_nxt = 1'b1;
        res_nxt.min_total_distance = (fin_w > SW'(COST_MAX)) ? COST_MAX
                                                            : COST_W'(fin_cost);
        res_nxt.too_many_houses = ovf_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      sp_r        <= '0;
      sel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      sp_r        <= sp_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;       ovf_r <= ovf_nxt;   i_r <= i_nxt;     k_r <= k_nxt;
    key_r <= key_nxt;   sum_r <= sum_nxt;   lim_r <= lim_nxt; t_r <= t_nxt;
    dc_r <= dc_nxt;     rci_r <= rci_nxt;   rcj_r <= rcj_nxt; m_r <= m_nxt;
    a_r <= a_nxt;       pm_r <= pm_nxt;     pi_r <= pi_nxt;   pj_r <= pj_nxt;
    prevc_r <= prevc_nxt;
    la_r <= la_nxt;     rb_r <= rb_nxt;
    lo_r <= lo_nxt;     hi_r <= hi_nxt;     olo_r <= olo_nxt; ohi_r <= ohi_nxt;
    mid_r <= mid_nxt;   top_r <= top_nxt;   j_r <= j_nxt;     bj_r <= bj_nxt;
    best_r <= best_nxt; first_r <= first_nxt;
    res_r <= res_nxt;
  end

  // split stack never outgrows the tree depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SD))
    else $error("split stack overflow");

  // best split must lie left of the point being solved
  a_split_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSHR) |-> (bj_r < mid_r))
    else $error("split point not left of mid");

  // a result is only produced into an empty slot
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN2) |-> !res_valid_r)
    else $error("result slot overwritten");

  // a job is taken only when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == S_IDLE && job_nempty))
    else $error("job taken while busy");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import lfp_pkg::*;

  localparam int MAX_HOUSES = 512;
  localparam int QUIET_LIMIT = 3000000;

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  line_facility_placement_dp #(.MAX_HOUSES(MAX_HOUSES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected results, oldest first
  out_item_t cost_q[$];
  int errors = 0;

  // predictor state
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
  int unsigned batch_pos[$];
  bit batch_drop = 0;
  longint pos_s[0:MAX_HOUSES];
  longint pre_s[0:MAX_HOUSES];
  longint row_a[0:MAX_HOUSES];
  longint row_b[0:MAX_HOUSES];

  // transactions are decided at the falling edge, where inputs are stable
  bit in_go, out_go, cfg_go;
  int quiet = 0;

  function automatic longint group_cost(int i, int j);
    int m;
    longint a;
    m = i + (j - i) / 2;
    a = pos_s[m];
    return a * (m - i + 1) - (pre_s[m] - pre_s[i-1]) + (pre_s[j] - pre_s[m]) - a * (j - m);
  endfunction

  function automatic longint best_placement();
    int n, k;
    longint c;
    n = batch_pos.size();
    k = (limit_reg == 0) ? 1 : int'(limit_reg);
    if (n == 0 || k >= n) return 0;
    batch_pos.sort();
    pre_s[0] = 0;
    for (int i = 1; i <= n; i++) begin
      pos_s[i] = longint'(batch_pos[i-1]);
      pre_s[i] = pre_s[i-1] + pos_s[i];
    end
    row_a[0] = 0;
    for (int i = 1; i <= n; i++) row_a[i] = group_cost(1, i);
    for (int t = 2; t <= k; t++) begin
      row_b[0] = 0;
      for (int i = 1; i <= n; i++) begin
        row_b[i] = row_a[i];
        for (int j = 1; j < i; j++) begin
          c = row_a[j] + group_cost(j + 1, i);
          if (c < row_b[i]) row_b[i] = c;
        end
      end
      for (int i = 0; i <= n; i++) row_a[i] = row_b[i];
    end
    return row_a[n];
  endfunction

  // update predictor for one accepted house; returns 1 when a result is due
  function automatic bit take_house(in_item_t it, output out_item_t r);
    longint c;
    if (batch_pos.size() < MAX_HOUSES) batch_pos.push_back(32'(it.house_position));
    else batch_drop = 1;
    if (!it.last_house) return 0;
    c = best_placement();
    if (c > longint'(COST_MAX)) c = longint'(COST_MAX);
    r.min_total_distance = c[COST_W-1:0];
    r.too_many_houses = batch_drop;
    batch_pos.delete();
    batch_drop = 0;
    return 1;
  endfunction

  always @(negedge clk) begin
    in_go = push && !full;
    cfg_go = cfg_valid && cfg_ready;
    out_go = pop && !empty;
    if (out_go) begin
      if (cost_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        if (out_data.min_total_distance !== cost_q[0].min_total_distance) begin
          $display("%0t: min_total_distance expected %0d actual %0d", $time,
                   cost_q[0].min_total_distance, out_data.min_total_distance);
          errors++;
        end
        if (out_data.too_many_houses !== cost_q[0].too_many_houses) begin
          $display("%0t: too_many_houses expected %0d actual %0d", $time,
                   cost_q[0].too_many_houses, out_data.too_many_houses);
          errors++;
        end
        void'(cost_q.pop_front());
      end
    end
    if (rst_n && !(in_go || out_go || cfg_go)) quiet++;
    else quiet = 0;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls on its own pattern: long ready runs, bursts of stalls
  int pop_run = 0;
  bit pop_mode = 1;
  always @(posedge clk) begin
    if (pop_run == 0) begin
      pop_mode = !pop_mode;
      pop_run = pop_mode ? $urandom_range(1, 30) : $urandom_range(1, 12);
    end
    pop_run--;
    pop <= rst_n && pop_mode;
  end

  int burst_left = 0;

  task automatic send_house(in_item_t it, bit typed, out_item_t typed_r);
    out_item_t r;
    push <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_go);
    if (take_house(it, r)) cost_q.push_back(typed ? typed_r : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        push <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk);
    push <= 0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_go);
    cfg_valid <= 0;
    limit_reg = v;
  endtask

  task automatic rand_house(bit last);
    in_item_t it;
    out_item_t none;
    none = '0;
    case ($urandom_range(0, 5))
      0: it.house_position = POS_W'($urandom_range(0, 7));
      1: it.house_position = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      2: it.house_position = POS_W'(20'hFFFFF - $urandom_range(0, 15));
      default: it.house_position = POS_W'($urandom);
    endcase
    it.last_house = last;
    send_house(it, 0, none);
  endtask

  typedef struct {
    int lim;   // -1 keeps the current limit
    int pos;
    bit last;
    bit typed;
    int cost;
    bit drop;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{-1, 5, 1, 1, 0, 0},
    '{-1, 0, 0, 0, 0, 0},
    '{-1, 1048575, 1, 1, 1048575, 0},
    '{0, 0, 0, 0, 0, 0},          // zero limit acts as one
    '{-1, 10, 1, 1, 10, 0},
    '{-1, 7, 0, 0, 0, 0},
    '{-1, 7, 0, 0, 0, 0},
    '{-1, 7, 1, 1, 0, 0},
    '{2, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0},
    '{-1, 1048575, 1, 1, 1, 0},   // two sites for three houses: far one alone
    '{-1, 3, 0, 0, 0, 0},
    '{-1, 900000, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0},
    '{-1, 1048574, 0, 0, 0, 0},
    '{-1, 500, 1, 0, 0, 0},
    '{512, 9, 0, 0, 0, 0},
    '{-1, 4, 1, 1, 0, 0},
    '{1023, 100, 0, 0, 0, 0},
    '{-1, 200, 1, 1, 0, 0}
  };

  initial begin
    in_item_t it;
    out_item_t r;
    int sent;
    int nb;
    logic [LIMIT_W-1:0] lv;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].lim >= 0) write_limit(LIMIT_W'(dir_tab[k].lim));
      it.house_position = POS_W'(dir_tab[k].pos);
      it.last_house = dir_tab[k].last;
      r.min_total_distance = COST_W'(dir_tab[k].cost);
      r.too_many_houses = dir_tab[k].drop;
      send_house(it, dir_tab[k].typed, r);
    end

    // full store: 512 held, then dropped houses, last one dropped too
    write_limit(LIMIT_W'(2));
    for (int i = 0; i < MAX_HOUSES + 5; i++) rand_house(i == MAX_HOUSES + 4);
    write_limit(LIMIT_W'(3));
    for (int i = 0; i < MAX_HOUSES; i++) rand_house(i == MAX_HOUSES - 1);
    write_limit(LIMIT_W'(1));
    for (int i = 0; i < MAX_HOUSES; i++) rand_house(i == MAX_HOUSES - 1);

    sent = 0;
    while (sent < 1950 - 3 * MAX_HOUSES) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 5))
          0: lv = '0;
          1: lv = LIMIT_W'(1);
          2: lv = LIMIT_W'(512);
          3: lv = LIMIT_W'(1023);
          default: lv = LIMIT_W'($urandom_range(1, 12));
        endcase
        write_limit(lv);
      end
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < nb; i++) rand_house(i == nb - 1);
      sent += nb;
    end

    @(posedge clk);
    push <= 0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lfp_pkg.sv
rtl/lfp_front.sv
rtl/lfp_jobq.sv
rtl/lfp_back.sv
rtl/line_facility_placement_dp.sv
bench/tb.sv
